// File: design/bdcl_pkg.sv
package bdcl_pkg;

  localparam int BTN_W = 6;
  localparam int IDX_W = 3;
  localparam int THR_W = 8;
  localparam logic [THR_W-1:0] THR_RESET = 8'd5;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef logic [BTN_W-1:0] btn_vec_t;
  typedef logic [THR_W-1:0] thr_t;

  typedef struct packed {
    cmd_t             command;
    btn_vec_t         raw_buttons;
    logic [IDX_W-1:0] button_index;
  } req_t;

  typedef struct packed {
    logic     any_committed;
    btn_vec_t button_state;
    btn_vec_t change_mask;
    logic     int_pending;
    logic     selected_state;
  } rsp_t;

endpackage

// File: design/bdcl_chan_if.sv
interface bdcl_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/button_debounce_change_latch_unit.sv
// Debouncer for a vector of button levels with a change latch and interrupt flag.
// Channels:
//   req  - command words: sample raw levels, read packet, clear all, query one button.
//   rsp  - exactly one result word per command word, in order.
//   cfg  - write-only debounce threshold (stable samples before a change commits).
// Throughput: one word per cycle; all button counters update in parallel in the
// cycle the word is accepted, and the result goes into an output register.
// A skid register behind the output lets one more word in while rsp is stalled;
// req.ready drops only while both registers hold undelivered results.
// cfg.ready is always high; write the threshold only while the block is idle.
// Reset (rst, synchronous): live state, mask, interrupt flag, candidate and all
// counters go to zero, threshold goes to 5, both result registers empty.
module button_debounce_change_latch_unit #(
  parameter int BUTTON_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst,
  bdcl_chan_if.sink   req,
  bdcl_chan_if.source rsp,
  bdcl_chan_if.sink   cfg
);

  localparam int W     = bdcl_pkg::BTN_W;
  localparam int LANES = (BUTTON_COUNT < W) ? BUTTON_COUNT : W;
  localparam logic [W-1:0] LANE_MASK = W'((1 << LANES) - 1);
  localparam int PAD_W = 2 ** bdcl_pkg::IDX_W;

  bdcl_pkg::thr_t     thr;
  bdcl_pkg::btn_vec_t live, live_next;
  bdcl_pkg::btn_vec_t latched, latched_next;
  bdcl_pkg::btn_vec_t pend, pend_next;
  bdcl_pkg::btn_vec_t cand, cand_next;
  logic               flag, flag_next;
  logic [bdcl_pkg::THR_W-1:0] cnt      [LANES];
  logic [bdcl_pkg::THR_W-1:0] cnt_next [LANES];
  logic [bdcl_pkg::THR_W:0]   sum;

  bdcl_pkg::btn_vec_t raw_m;
  logic [PAD_W-1:0]   live_pad;
  bdcl_pkg::rsp_t     res;
  bdcl_pkg::rsp_t     out_word, skid_word;
  logic               out_v, skid_v;
  logic               acc, pop;

  assign req.ready = !skid_v;
  assign acc       = req.valid && req.ready;
  assign pop       = out_v && rsp.ready;
  assign rsp.valid = out_v;
  assign rsp.data  = out_word;
  assign cfg.ready = 1'b1;

  assign raw_m    = req.data.raw_buttons & LANE_MASK;
  assign live_pad = PAD_W'(live);

  always_comb begin
    live_next    = live;
    latched_next = latched;
    pend_next    = pend;
    cand_next    = cand;
    flag_next    = flag;
    cnt_next     = cnt;
    sum          = '0;
    res          = '0;
    case (req.data.command)
      bdcl_pkg::CMD_SAMPLE: begin
        if (raw_m != cand) begin
          // new candidate: restart every counter, nothing counted this word
          cand_next = raw_m;
          for (int i = 0; i < LANES; i++) begin
            cnt_next[i] = '0;
          end
        end else begin
          for (int i = 0; i < LANES; i++) begin
            if (raw_m[i] != live[i]) begin
              sum = {1'b0, cnt[i]} + 9'd1;
              // threshold 0 behaves as 1
              if (sum >= {1'b0, thr}) begin
                live_next[i]      = raw_m[i];
                pend_next[i]      = 1'b1;
                flag_next         = 1'b1;
                cnt_next[i]       = '0;
                res.any_committed = 1'b1;
              end else begin
                cnt_next[i] = sum[bdcl_pkg::THR_W-1:0];
              end
            end else begin
              cnt_next[i] = '0;
            end
          end
        end
        res.button_state = live_next;
        res.change_mask  = pend_next;
      end
      bdcl_pkg::CMD_READ: begin
        latched_next     = live;
        res.button_state = latched_next;
        res.change_mask  = pend;
        pend_next        = '0;
        flag_next        = 1'b0;
      end
      bdcl_pkg::CMD_CLEAR: begin
        live_next    = '0;
        latched_next = '0;
        pend_next    = '0;
        flag_next    = 1'b0;
        for (int i = 0; i < LANES; i++) begin
          cnt_next[i] = '0;
        end
      end
      bdcl_pkg::CMD_QUERY: begin
        if ({1'b0, req.data.button_index} < (bdcl_pkg::IDX_W + 1)'(LANES)) begin
          res.selected_state = live_pad[req.data.button_index];
        end
        res.button_state = live;
        res.change_mask  = pend;
      end
      default: begin
        res.button_state = live;
        res.change_mask  = pend;
      end
    endcase
    res.int_pending = flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      latched <= '0;
      pend    <= '0;
      cand    <= '0;
      flag    <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        cnt[i] <= '0;
      end
    end else if (acc) begin
      live    <= live_next;
      latched <= latched_next;
      pend    <= pend_next;
      cand    <= cand_next;
      flag    <= flag_next;
      cnt     <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= bdcl_pkg::THR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      thr <= cfg.data;
    end
  end

  // output register plus skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (pop) begin
      if (skid_v) begin
        skid_v <= 1'b0;
      end else if (!acc) begin
        out_v <= 1'b0;
      end
    end else if (acc) begin
      if (!out_v) begin
        out_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v) begin
        out_word <= skid_word;
      end else if (acc) begin
        out_word <= res;
      end
    end else if (acc) begin
      if (!out_v) begin
        out_word <= res;
      end else begin
        skid_word <= res;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid word held with empty output register");

  a_flag_tracks_mask: assert property (@(posedge clk) disable iff (rst)
    flag == (pend != '0))
    else $error("interrupt flag out of step with change mask");

  a_unused_lanes_zero: assert property (@(posedge clk) disable iff (rst)
    ((live | pend | cand) & ~LANE_MASK) == '0)
    else $error("state bit set for a button that does not exist");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (acc && req.data.command == bdcl_pkg::CMD_CLEAR)
      |=> (live == '0 && pend == '0 && !flag && cand == $past(cand)))
    else $error("clear left state behind or touched candidate");

  a_no_lost_word: assert property (@(posedge clk) disable iff (rst)
    (out_v && !rsp.ready) |=> out_v)
    else $error("undelivered result dropped");
`endif

endmodule

// File: sim/button_debounce_change_latch_unit_tb.sv
module button_debounce_change_latch_unit_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 40;

  // Predicts each result word from its command word and holds the ones still due.
  class button_latch_model;
    bdcl_pkg::thr_t threshold;
    bdcl_pkg::btn_vec_t live;
    bdcl_pkg::btn_vec_t latched;
    bdcl_pkg::btn_vec_t changes;
    bdcl_pkg::btn_vec_t candidate;
    logic irq;
    logic [7:0] counts [bdcl_pkg::BTN_W];
    bdcl_pkg::rsp_t expected_words[$];
    int errors;

    function new();
      threshold = bdcl_pkg::THR_RESET;
      live = '0;
      latched = '0;
      changes = '0;
      candidate = '0;
      irq = 1'b0;
      errors = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      foreach (counts[i]) counts[i] = '0;
    endfunction

    function logic sample(bdcl_pkg::btn_vec_t raw);
      logic any;
      any = 1'b0;
      if (raw != candidate) begin
        // new candidate: restart every counter, nothing counted this time
        candidate = raw;
        clear_counts();
        return 1'b0;
      end
      for (int i = 0; i < bdcl_pkg::BTN_W; i++) begin
        if (raw[i] != live[i]) begin
          counts[i] = counts[i] + 8'd1;
          if (counts[i] >= threshold) begin
            live[i] = raw[i];
            changes[i] = 1'b1;
            counts[i] = '0;
            irq = 1'b1;
            any = 1'b1;
          end
        end else begin
          counts[i] = '0;
        end
      end
      return any;
    endfunction

    function void note_word(bdcl_pkg::req_t w);
      bdcl_pkg::rsp_t e;
      e = '0;
      case (w.command)
        bdcl_pkg::CMD_SAMPLE: begin
          e.any_committed = sample(w.raw_buttons);
          e.button_state = live;
          e.change_mask = changes;
        end
        bdcl_pkg::CMD_READ: begin
          latched = live;
          e.button_state = latched;
          e.change_mask = changes;
          changes = '0;
          irq = 1'b0;
        end
        bdcl_pkg::CMD_CLEAR: begin
          live = '0;
          latched = '0;
          changes = '0;
          irq = 1'b0;
          clear_counts();
          e.button_state = live;
          e.change_mask = changes;
        end
        default: begin
          if (w.button_index < bdcl_pkg::BTN_W) e.selected_state = live[w.button_index];
          e.button_state = live;
          e.change_mask = changes;
        end
      endcase
      e.int_pending = irq;
      expected_words.push_back(e);
    endfunction

    function void check_word(bdcl_pkg::rsp_t got);
      bdcl_pkg::rsp_t e;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (got.any_committed !== e.any_committed) begin
        $error("any_committed: expected %0d, got %0d", e.any_committed, got.any_committed);
        errors++;
      end
      if (got.button_state !== e.button_state) begin
        $error("button_state: expected %h, got %h", e.button_state, got.button_state);
        errors++;
      end
      if (got.change_mask !== e.change_mask) begin
        $error("change_mask: expected %h, got %h", e.change_mask, got.change_mask);
        errors++;
      end
      if (got.int_pending !== e.int_pending) begin
        $error("int_pending: expected %0d, got %0d", e.int_pending, got.int_pending);
        errors++;
      end
      if (got.selected_state !== e.selected_state) begin
        $error("selected_state: expected %0d, got %0d", e.selected_state, got.selected_state);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int cycle_count;
  int hold_reqs = 0;
  bit steady = 1'b0;
  button_latch_model sb = new();

  bdcl_chan_if #(.payload_t(bdcl_pkg::req_t)) req_if ();
  bdcl_chan_if #(.payload_t(bdcl_pkg::rsp_t)) rsp_if ();
  bdcl_chan_if #(.payload_t(bdcl_pkg::thr_t)) cfg_if ();

  button_debounce_change_latch_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bdcl_pkg::btn_vec_t rand_btn();
    return bdcl_pkg::btn_vec_t'($urandom);
  endfunction

  function automatic logic [bdcl_pkg::IDX_W-1:0] rand_idx();
    return (bdcl_pkg::IDX_W)'($urandom);
  endfunction

  task automatic send_word(input bdcl_pkg::req_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= w;
    do @(posedge clk); while (!req_if.ready);
    sb.note_word(w);
  endtask

  task automatic send_cmd(input bdcl_pkg::cmd_t c, input bdcl_pkg::btn_vec_t raw,
                          input logic [bdcl_pkg::IDX_W-1:0] idx);
    bdcl_pkg::req_t w;
    w.command = c;
    w.raw_buttons = raw;
    w.button_index = idx;
    send_word(w);
  endtask

  // always lets the clock tick with valid low, so valid is never lowered and raised at once
  task automatic drain_words();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input bdcl_pkg::thr_t v);
    drain_words();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.threshold = v;
  endtask

  task automatic run_phase(input int count);
    int n;
    int pick;
    int len;
    int cap;
    bdcl_pkg::btn_vec_t v;
    n = 0;
    while (n < count) begin
      steady = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // held level long enough (mostly) to commit
        v = rand_btn();
        cap = (sb.threshold == 0) ? 1 : int'(sb.threshold);
        if ($urandom_range(0, 1) == 1) len = cap + 1 + $urandom_range(0, 2);
        else len = $urandom_range(1, cap + 2);
        repeat (len) send_cmd(bdcl_pkg::CMD_SAMPLE, v, rand_idx());
        n += len;
      end else if (pick < 70) begin
        len = $urandom_range(1, 4);
        repeat (len) send_cmd(bdcl_pkg::CMD_SAMPLE, rand_btn(), rand_idx());
        n += len;
      end else if (pick < 80) begin
        send_cmd(bdcl_pkg::CMD_READ, rand_btn(), rand_idx());
        n++;
      end else if (pick < 90) begin
        send_cmd(bdcl_pkg::CMD_QUERY, rand_btn(), rand_idx());
        n++;
      end else if (pick < 95) begin
        send_cmd(bdcl_pkg::CMD_CLEAR, rand_btn(), rand_idx());
        n++;
      end else if (pick < 97) begin
        drain_words();
      end else begin
        send_cmd(bdcl_pkg::CMD_SAMPLE, sb.candidate, rand_idx());
        n++;
      end
    end
    steady = 1'b0;
  endtask

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int stall;
    int hold_seen;
    hold_seen = 0;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      sb.check_word(rsp_if.data);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL button_debounce_change_latch_unit");
    $finish;
  end

  initial begin
    bdcl_pkg::thr_t plan [6];
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset threshold of 5
    send_cmd(bdcl_pkg::CMD_QUERY, '0, 3'd0);
    send_cmd(bdcl_pkg::CMD_QUERY, '1, 3'd5);
    send_cmd(bdcl_pkg::CMD_QUERY, '0, 3'd6);
    send_cmd(bdcl_pkg::CMD_QUERY, '1, 3'd7);
    repeat (6) send_cmd(bdcl_pkg::CMD_SAMPLE, 6'h3F, 3'd0);
    send_cmd(bdcl_pkg::CMD_QUERY, '0, 3'd5);
    send_cmd(bdcl_pkg::CMD_QUERY, '0, 3'd6);
    send_cmd(bdcl_pkg::CMD_READ, '0, 3'd0);
    send_cmd(bdcl_pkg::CMD_READ, '1, 3'd7);
    repeat (2) send_cmd(bdcl_pkg::CMD_SAMPLE, 6'h2A, 3'd0);
    // a bounce restarts the counters
    send_cmd(bdcl_pkg::CMD_SAMPLE, 6'h15, 3'd0);
    repeat (6) send_cmd(bdcl_pkg::CMD_SAMPLE, 6'h2A, 3'd0);
    send_cmd(bdcl_pkg::CMD_CLEAR, 6'h3F, 3'd7);
    send_cmd(bdcl_pkg::CMD_QUERY, '0, 3'd1);

    // fill the block while the receiver holds off
    hold_reqs++;
    steady = 1'b1;
    repeat (12) send_cmd(bdcl_pkg::CMD_SAMPLE, 6'h3F, rand_idx());
    steady = 1'b0;
    drain_words();
    run_phase(150);

    plan[0] = 8'd1;
    plan[1] = 8'd255;
    plan[2] = 8'd0;
    plan[3] = 8'd2;
    plan[4] = bdcl_pkg::thr_t'($urandom_range(1, 16));
    plan[5] = bdcl_pkg::THR_RESET;
    foreach (plan[i]) begin
      write_threshold(plan[i]);
      run_phase(plan[i] == 8'd255 ? 400 : 230);
    end

    drain_words();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("PASS button_debounce_change_latch_unit");
    end else begin
      if (sb.expected_words.size() != 0)
        $error("%0d result words never arrived", sb.expected_words.size());
      $display("FAIL button_debounce_change_latch_unit");
    end
    $finish;
  end

endmodule

// File: sim.f
design/bdcl_pkg.sv
design/bdcl_chan_if.sv
design/button_debounce_change_latch_unit.sv
sim/button_debounce_change_latch_unit_tb.sv
